// ===== sv/lom_pkg.sv =====
`timescale 1ns / 1ps
package lom_pkg;

  // Default book geometry
  localparam int DEFAULT_BOOK_DEPTH = 1024;
  localparam int DEFAULT_PRICE_BITS = 20;
  localparam int DEFAULT_QTY_BITS   = 20;

  // Fixed port widths
  localparam int PRICE_W = 20;
  localparam int QTY_W   = 20;
  localparam int VALUE_W = 40;
  localparam int TOTAL_W = 48;
  localparam int SEQ_W   = 32;

  // Book select bit in the memory address
  localparam logic BOOK_ASK = 1'b0;
  localparam logic BOOK_BID = 1'b1;

  // Order side codes
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

endpackage

// ===== sv/lom_book_mem.sv =====
`timescale 1ns / 1ps
module lom_book_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 72
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/limit_order_matcher.sv =====
`timescale 1ns / 1ps
// Price-time priority limit order matcher. Each transaction on the input
// channel is one limit order (op: 0 sell, 1 buy; price; quantity) and yields
// exactly one result transaction: filled quantity, the order's trade value
// (fills times the incoming price, saturating at 2^40-1), the running total
// of all trade value (saturating at 2^48-1), and rested/dropped flags. Both
// books live in one single-port-write, registered-read memory of 2^(SW+1)
// entries, SW = $clog2(BOOK_DEPTH) but at least 1. Each fill scans the
// opposite book one entry per cycle for the best resting order, then
// trims that order in place or, if emptied, moves the book's last entry
// into its slot, and adds the fill's value. When the order is used up, the
// book is empty or the best order does not cross, any remainder rests or is
// dropped and the result is issued. One order is worked at a time; the
// next order is taken while the previous result still waits on the output
// register. The books are empty after reset; no clearing pass.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH,
  parameter int PRICE_BITS = DEFAULT_PRICE_BITS,
  parameter int QTY_BITS   = DEFAULT_QTY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [PRICE_W-1:0] price,
  input  logic [QTY_W-1:0]   quantity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [QTY_W-1:0]   filled_quantity,
  output logic [VALUE_W-1:0] order_value,
  output logic [TOTAL_W-1:0] total_value,
  output logic               rested,
  output logic               dropped
);

  localparam int SW   = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW   = $clog2(BOOK_DEPTH + 1);
  localparam int KW   = PRICE_BITS + SEQ_W;
  localparam int EW   = KW + QTY_BITS;
  localparam int VW   = PRICE_BITS + QTY_BITS;
  localparam int SUMW = ((VW > TOTAL_W) ? VW : TOTAL_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MATCH  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_MOVE   = 8'b0001_0000,
    S_ACCUM  = 8'b0010_0000,
    S_REST   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t              state;
  logic                side;
  logic [PRICE_BITS-1:0] ord_price;
  logic [QTY_BITS-1:0] qty0;
  logic [QTY_BITS-1:0] qty;
  logic [SEQ_W-1:0]    seq;
  logic [VW-1:0]       value;
  logic [VW-1:0]       product;
  logic [CW-1:0]       bid_count;
  logic [CW-1:0]       ask_count;
  logic [TOTAL_W-1:0]  total;
  logic [SW-1:0]       rd_slot;
  logic [SW-1:0]       best_slot;
  logic [EW-1:0]       best_entry;
  logic                rest_flag;
  logic                drop_flag;

  // memory port
  logic            mem_rd_en;
  logic [SW:0]     mem_rd_addr;
  logic [EW-1:0]   mem_rd_data;
  logic            mem_wr_en;
  logic [SW:0]     mem_wr_addr;
  logic [EW-1:0]   mem_wr_data;

  logic                  opp_book;
  logic [CW-1:0]         opp_count;
  logic [CW-1:0]         opp_last;
  logic [CW-1:0]         own_count;
  logic                  own_room;
  logic [PRICE_BITS-1:0] best_part;
  logic                  crossing;
  logic [QTY_BITS-1:0]   best_rem;
  logic                  partial;
  logic [QTY_BITS-1:0]   fill;
  logic                  better;
  logic [SUMW-1:0]       value_ext;
  logic [SUMW-1:0]       total_sum;

  // The opposite book is asks for a buy and bids for a sell
  assign opp_book  = (side == SIDE_BUY) ? BOOK_ASK : BOOK_BID;
  assign opp_count = (side == SIDE_BUY) ? ask_count : bid_count;
  assign own_count = (side == SIDE_BUY) ? bid_count : ask_count;
  assign opp_last  = opp_count - CW'(1);
  assign own_room  = (own_count < CW'(BOOK_DEPTH));

  // Bid keys hold the complemented price, so the smallest key is always best
  assign best_part = best_entry[EW-1 -: PRICE_BITS];
  assign best_rem  = best_entry[QTY_BITS-1:0];
  assign crossing  = (side == SIDE_BUY) ? (best_part <= ord_price)
                                        : (~best_part >= ord_price);
  assign partial   = (best_rem > qty);
  assign fill      = partial ? qty : best_rem;

  // Strict compare keeps the lower slot on an exact key tie
  assign better = (rd_slot == '0) ||
                  (mem_rd_data[EW-1:QTY_BITS] < best_entry[EW-1:QTY_BITS]);

  assign value_ext = SUMW'(value);
  assign total_sum = SUMW'(total) + value_ext;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = {opp_book, SW'(0)};
    mem_wr_en   = 1'b0;
    mem_wr_addr = {opp_book, best_slot};
    mem_wr_data = mem_rd_data;
    case (state)
      S_MATCH: begin
        mem_rd_en = 1'b1;
      end
      S_SCAN: begin
        if (CW'(rd_slot) != opp_last) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {opp_book, rd_slot + SW'(1)};
        end
      end
      S_DECIDE: begin
        if (crossing && partial) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = {best_entry[EW-1:QTY_BITS], best_rem - qty};
        end else if (crossing) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {opp_book, opp_last[SW-1:0]};
        end
      end
      S_MOVE: begin
        mem_wr_en = 1'b1;
      end
      S_REST: begin
        if ((qty != '0) && own_room) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = {side, own_count[SW-1:0]};
          mem_wr_data = (side == SIDE_BUY) ? {~ord_price, seq, qty}
                                           : {ord_price, seq, qty};
        end
      end
      default: begin
      end
    endcase
  end

  lom_book_mem #(
    .ADDR_W(SW + 1),
    .DATA_W(EW)
  ) u_book_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bid_count <= '0;
      ask_count <= '0;
      seq       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the delivered result unless a new one replaces it this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // latch the order, masked to the configured widths
            side      <= op;
            ord_price <= PRICE_BITS'(price);
            qty0      <= QTY_BITS'(quantity);
            qty       <= QTY_BITS'(quantity);
            value     <= '0;
            rest_flag <= 1'b0;
            drop_flag <= 1'b0;
            state     <= S_MATCH;
          end
        end
        S_MATCH: begin
          rd_slot <= '0;
          if ((qty == '0) || (opp_count == '0)) begin
            state <= S_REST;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (better) begin
            best_slot  <= rd_slot;
            best_entry <= mem_rd_data;
          end
          if (CW'(rd_slot) == opp_last) begin
            state <= S_DECIDE;
          end else begin
            rd_slot <= rd_slot + SW'(1);
          end
        end
        S_DECIDE: begin
          if (!crossing) begin
            state <= S_REST;
          end else begin
            product <= VW'(fill) * VW'(ord_price);
            qty     <= qty - fill;
            state   <= partial ? S_ACCUM : S_MOVE;
          end
        end
        S_MOVE: begin
          // last entry now sits in the emptied slot; shrink the book
          if (side == SIDE_BUY) begin
            ask_count <= ask_count - CW'(1);
          end else begin
            bid_count <= bid_count - CW'(1);
          end
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          value <= value + product;
          state <= S_MATCH;
        end
        S_REST: begin
          if (qty != '0) begin
            if (own_room) begin
              rest_flag <= 1'b1;
              if (side == SIDE_BUY) begin
                bid_count <= bid_count + CW'(1);
              end else begin
                ask_count <= ask_count + CW'(1);
              end
            end else begin
              drop_flag <= 1'b1;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            filled_quantity <= QTY_W'(qty0 - qty);
            order_value     <= (value_ext > SUMW'({VALUE_W{1'b1}})) ?
                               {VALUE_W{1'b1}} : value_ext[VALUE_W-1:0];
            if (total_sum > SUMW'({TOTAL_W{1'b1}})) begin
              total       <= {TOTAL_W{1'b1}};
              total_value <= {TOTAL_W{1'b1}};
            end else begin
              total       <= total_sum[TOTAL_W-1:0];
              total_value <= total_sum[TOTAL_W-1:0];
            end
            rested <= rest_flag;
            dropped <= drop_flag;
            seq    <= seq + SEQ_W'(1);
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_bid_bound: assert property (@(posedge clk) disable iff (rst)
    bid_count <= CW'(BOOK_DEPTH)) else $error("bid book over depth");

  a_ask_bound: assert property (@(posedge clk) disable iff (rst)
    ask_count <= CW'(BOOK_DEPTH)) else $error("ask book over depth");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINISH) |=> $stable(total)) else $error("total changed mid order");

  a_no_flags_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rested && dropped)) else $error("rested and dropped together");

endmodule
